### src/gpm_pkg.sv
// Shared types and constants for the glob pattern matcher.
// Used by gpm_ctrl, gpm_dp and glob_pattern_matcher; depends on nothing.
package gpm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int MAX_SUBJECT_DEF = 256;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ESC   = 8'h5C;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PAT   = 2'd1,
        OP_SUB   = 2'd2,
        OP_EVAL  = 2'd3
    } opcode_t;

    // pointer updates in the datapath
    typedef enum logic [3:0] {
        DP_NOP,
        DP_START,
        DP_STAR,
        DP_ADV1,
        DP_ADV2,
        DP_BACK,
        DP_CLOSE_INIT,
        DP_CLOSE_INC,
        DP_SET_INIT,
        DP_SET_STEP,
        DP_SET_TAKE,
        DP_P_INC
    } dp_op_t;

    // pattern read address source
    typedef enum logic [1:0] {
        PSEL_P,
        PSEL_P1,
        PSEL_CLOSE,
        PSEL_K
    } pat_sel_t;

    typedef struct packed {
        dp_op_t   op;
        pat_sel_t pat_sel;
        logic     rd_pat;
        logic     rd_sub;
        logic     wr_pat;
        logic     wr_sub;
        logic     clr_pat;
        logic     clr_sub;
    } cmd_t;

    typedef struct packed {
        logic s_lt_n;
        logic p_lt_n;
        logic p1_lt_n;
        logic close_lt_n;
        logic k_lt_close;
        logic pd_is_star;
        logic pd_is_query;
        logic pd_is_open;
        logic pd_is_esc;
        logic pd_is_close;
        logic pd_eq_sc;
        logic sc_is_open;
        logic have_star;
        logic found;
        logic neg;
        logic ovf;
    } status_t;

endpackage

### src/gpm_dp.sv
// Datapath of the glob pattern matcher: pattern and subject memories,
// counts, walk pointers and compares. Depends on gpm_pkg.
module gpm_dp #(
    parameter int MAX_PATTERN = gpm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SUBJECT = gpm_pkg::MAX_SUBJECT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gpm_pkg::cmd_t    cmd,
    input  logic [7:0]       data_byte,
    output gpm_pkg::status_t st
);

    localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SAW = (MAX_SUBJECT > 1) ? $clog2(MAX_SUBJECT) : 1;
    localparam int PCW = $clog2(MAX_PATTERN + 1);
    localparam int SCW = $clog2(MAX_SUBJECT + 1);

    logic [7:0] pat_mem [MAX_PATTERN];
    logic [7:0] sub_mem [MAX_SUBJECT];
    logic [7:0] pd_reg;
    logic [7:0] sc_reg;

    logic [PCW-1:0] pn_reg, p_reg, p_next, star_p_reg, star_p_next;
    logic [PCW-1:0] close_reg, close_next, k_reg, k_next;
    logic [SCW-1:0] sn_reg, s_reg, s_next, star_s_reg, star_s_next;
    logic           have_star_reg, have_star_next;
    logic           found_reg, found_next, neg_reg, neg_next;
    logic           ovf_reg;
    logic [PCW:0]   p_inc1, p_inc2;
    logic [PCW-1:0] pat_addr;

    assign p_inc1 = {1'b0, p_reg} + (PCW+1)'(1);
    assign p_inc2 = {1'b0, p_reg} + (PCW+1)'(2);

    always_comb
    begin
        case (cmd.pat_sel)
            gpm_pkg::PSEL_P:     pat_addr = p_reg;
            gpm_pkg::PSEL_P1:    pat_addr = p_inc1[PCW-1:0];
            gpm_pkg::PSEL_CLOSE: pat_addr = close_reg;
            gpm_pkg::PSEL_K:     pat_addr = k_reg;
            default:             pat_addr = p_reg;
        endcase
    end

    // memories: writes only while idle, reads registered
    always_ff @(posedge clk)
    begin
        if (cmd.wr_pat && (pn_reg < PCW'(MAX_PATTERN)))
            pat_mem[pn_reg[PAW-1:0]] <= data_byte;
        if (cmd.wr_sub && (sn_reg < SCW'(MAX_SUBJECT)))
            sub_mem[sn_reg[SAW-1:0]] <= data_byte;
        if (cmd.rd_pat)
            pd_reg <= pat_mem[pat_addr[PAW-1:0]];
        if (cmd.rd_sub)
            sc_reg <= sub_mem[s_reg[SAW-1:0]];
    end

    always_comb
    begin
        p_next         = p_reg;
        s_next         = s_reg;
        star_p_next    = star_p_reg;
        star_s_next    = star_s_reg;
        have_star_next = have_star_reg;
        close_next     = close_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        neg_next       = neg_reg;
        case (cmd.op)
            gpm_pkg::DP_START:
            begin
                p_next         = '0;
                s_next         = '0;
                have_star_next = 1'b0;
            end
            gpm_pkg::DP_STAR:
            begin
                have_star_next = 1'b1;
                star_p_next    = p_reg;
                star_s_next    = s_reg;
                p_next         = p_inc1[PCW-1:0];
            end
            gpm_pkg::DP_ADV1:
            begin
                p_next = p_inc1[PCW-1:0];
                s_next = s_reg + SCW'(1);
            end
            gpm_pkg::DP_ADV2:
            begin
                p_next = p_inc2[PCW-1:0];
                s_next = s_reg + SCW'(1);
            end
            gpm_pkg::DP_BACK:
            begin
                p_next      = star_p_reg + PCW'(1);
                star_s_next = star_s_reg + SCW'(1);
                s_next      = star_s_reg + SCW'(1);
            end
            gpm_pkg::DP_CLOSE_INIT: close_next = p_inc1[PCW-1:0];
            gpm_pkg::DP_CLOSE_INC:  close_next = close_reg + PCW'(1);
            gpm_pkg::DP_SET_INIT:
            begin
                neg_next   = (pd_reg == gpm_pkg::CH_CARET);
                found_next = 1'b0;
                k_next     = (pd_reg == gpm_pkg::CH_CARET) ? p_inc2[PCW-1:0]
                                                            : p_inc1[PCW-1:0];
            end
            gpm_pkg::DP_SET_STEP:
            begin
                if (pd_reg == sc_reg)
                    found_next = 1'b1;
                k_next = k_reg + PCW'(1);
            end
            gpm_pkg::DP_SET_TAKE:
            begin
                p_next = close_reg + PCW'(1);
                s_next = s_reg + SCW'(1);
            end
            gpm_pkg::DP_P_INC: p_next = p_inc1[PCW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pn_reg        <= '0;
            sn_reg        <= '0;
            ovf_reg       <= 1'b0;
            p_reg         <= '0;
            s_reg         <= '0;
            star_p_reg    <= '0;
            star_s_reg    <= '0;
            have_star_reg <= 1'b0;
            close_reg     <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            p_reg         <= p_next;
            s_reg         <= s_next;
            star_p_reg    <= star_p_next;
            star_s_reg    <= star_s_next;
            have_star_reg <= have_star_next;
            close_reg     <= close_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            neg_reg       <= neg_next;
            if (cmd.clr_pat)
            begin
                pn_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.wr_pat)
            begin
                if (pn_reg < PCW'(MAX_PATTERN))
                    pn_reg <= pn_reg + PCW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            else if (cmd.wr_sub)
            begin
                if (sn_reg < SCW'(MAX_SUBJECT))
                    sn_reg <= sn_reg + SCW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.clr_sub)
                sn_reg <= '0;
        end
    end

    always_comb
    begin
        st.s_lt_n      = (s_reg < sn_reg);
        st.p_lt_n      = (p_reg < pn_reg);
        st.p1_lt_n     = (p_inc1 < {1'b0, pn_reg});
        st.close_lt_n  = (close_reg < pn_reg);
        st.k_lt_close  = (k_reg < close_reg);
        st.pd_is_star  = (pd_reg == gpm_pkg::CH_STAR);
        st.pd_is_query = (pd_reg == gpm_pkg::CH_QUERY);
        st.pd_is_open  = (pd_reg == gpm_pkg::CH_OPEN);
        st.pd_is_esc   = (pd_reg == gpm_pkg::CH_ESC);
        st.pd_is_close = (pd_reg == gpm_pkg::CH_CLOSE);
        st.pd_eq_sc    = (pd_reg == sc_reg);
        st.sc_is_open  = (sc_reg == gpm_pkg::CH_OPEN);
        st.have_star   = have_star_reg;
        st.found       = found_reg;
        st.neg         = neg_reg;
        st.ovf         = ovf_reg;
    end

endmodule

### src/gpm_ctrl.sv
// Controller of the glob pattern matcher: intake, match walk sequencing
// and the result register. Depends on gpm_pkg.
module gpm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       opcode,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             matched,
    output logic             overflow,
    output gpm_pkg::cmd_t    cmd,
    input  gpm_pkg::status_t st
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DEC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CARET,
        S_SET_RD,
        S_SET_CHK,
        S_ESC_CHK,
        S_TR_RD,
        S_TR_CHK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   res_reg, res_next;
    logic   out_valid_reg, out_valid_next;
    logic   matched_reg, matched_next;
    logic   overflow_reg, overflow_next;
    logic   mismatch;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign overflow  = overflow_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.op         = gpm_pkg::DP_NOP;
        cmd.pat_sel    = gpm_pkg::PSEL_P;
        state_next     = state_reg;
        res_next       = res_reg;
        mismatch       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        matched_next   = matched_reg;
        overflow_next  = overflow_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    case (gpm_pkg::opcode_t'(opcode))
                        gpm_pkg::OP_CLEAR: cmd.clr_pat = 1'b1;
                        gpm_pkg::OP_PAT:   cmd.wr_pat = 1'b1;
                        gpm_pkg::OP_SUB:   cmd.wr_sub = 1'b1;
                        gpm_pkg::OP_EVAL:
                        begin
                            cmd.op     = gpm_pkg::DP_START;
                            state_next = S_RD;
                        end
                        default: ;
                    endcase
                end
            S_RD:
                if (!st.s_lt_n)
                    state_next = S_TR_RD;
                else
                begin
                    cmd.rd_pat = 1'b1;
                    cmd.rd_sub = 1'b1;
                    state_next = S_DEC;
                end
            S_DEC:
                if (st.p_lt_n && st.pd_is_star)
                begin
                    cmd.op     = gpm_pkg::DP_STAR;
                    state_next = S_RD;
                end
                else if (st.p_lt_n && st.pd_is_query)
                begin
                    cmd.op     = gpm_pkg::DP_ADV1;
                    state_next = S_RD;
                end
                else if (st.p_lt_n && st.pd_is_open)
                begin
                    cmd.op     = gpm_pkg::DP_CLOSE_INIT;
                    state_next = S_SCAN_RD;
                end
                else if (st.p_lt_n && st.pd_is_esc)
                begin
                    if (st.p1_lt_n)
                    begin
                        cmd.rd_pat  = 1'b1;
                        cmd.pat_sel = gpm_pkg::PSEL_P1;
                        state_next  = S_ESC_CHK;
                    end
                    else
                        mismatch = 1'b1;
                end
                else if (st.p_lt_n && st.pd_eq_sc)
                begin
                    cmd.op     = gpm_pkg::DP_ADV1;
                    state_next = S_RD;
                end
                else
                    mismatch = 1'b1;
            S_SCAN_RD:
                if (st.close_lt_n)
                begin
                    cmd.rd_pat  = 1'b1;
                    cmd.pat_sel = gpm_pkg::PSEL_CLOSE;
                    state_next  = S_SCAN_CHK;
                end
                else if (st.sc_is_open)
                begin
                    // unclosed bracket matches a literal '['; any other byte ends the walk unmatched
                    cmd.op     = gpm_pkg::DP_ADV1;
                    state_next = S_RD;
                end
                else
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
            S_SCAN_CHK:
                if (st.pd_is_close)
                begin
                    cmd.rd_pat  = 1'b1;
                    cmd.pat_sel = gpm_pkg::PSEL_P1;
                    state_next  = S_CARET;
                end
                else
                begin
                    cmd.op     = gpm_pkg::DP_CLOSE_INC;
                    state_next = S_SCAN_RD;
                end
            S_CARET:
            begin
                cmd.op     = gpm_pkg::DP_SET_INIT;
                state_next = S_SET_RD;
            end
            S_SET_RD:
                if (st.found || !st.k_lt_close)
                begin
                    if (st.found != st.neg)
                    begin
                        cmd.op     = gpm_pkg::DP_SET_TAKE;
                        state_next = S_RD;
                    end
                    else
                        mismatch = 1'b1;
                end
                else
                begin
                    cmd.rd_pat  = 1'b1;
                    cmd.pat_sel = gpm_pkg::PSEL_K;
                    state_next  = S_SET_CHK;
                end
            S_SET_CHK:
            begin
                cmd.op     = gpm_pkg::DP_SET_STEP;
                state_next = S_SET_RD;
            end
            S_ESC_CHK:
                if (st.pd_eq_sc)
                begin
                    cmd.op     = gpm_pkg::DP_ADV2;
                    state_next = S_RD;
                end
                else
                    mismatch = 1'b1;
            S_TR_RD:
                if (st.p_lt_n)
                begin
                    cmd.rd_pat = 1'b1;
                    state_next = S_TR_CHK;
                end
                else
                begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end
            S_TR_CHK:
                if (st.pd_is_star)
                begin
                    cmd.op     = gpm_pkg::DP_P_INC;
                    state_next = S_TR_RD;
                end
                else
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
            S_DONE:
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.clr_sub    = 1'b1;
                    out_valid_next = 1'b1;
                    matched_next   = res_reg && !st.ovf;
                    overflow_next  = st.ovf;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase

        // back to the byte after the last star, or fail
        if (mismatch)
        begin
            if (st.have_star)
            begin
                cmd.op     = gpm_pkg::DP_BACK;
                state_next = S_RD;
            end
            else
            begin
                res_next   = 1'b0;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            matched_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            matched_reg   <= matched_next;
            overflow_reg  <= overflow_next;
        end
    end

endmodule

### src/glob_pattern_matcher.sv
// Glob pattern matcher top level: joins gpm_ctrl and gpm_dp.
// Depends on gpm_pkg, gpm_ctrl, gpm_dp.
//
// Input channel (in_valid/in_stall, opcode, data_byte): clear pattern,
// append pattern byte, append subject byte, evaluate. Clear and append
// items are taken back to back. An evaluate item stalls intake while a
// sequencer walks both memories through one pattern read port and one
// subject read port: a plain step (star, '?', literal, mismatch) reads
// both memories, then decodes; an escape also reads the escaped byte. A
// closed bracket is scanned to its closing bracket, checked for a caret,
// then its set members are tested; an unclosed one is scanned, then
// compared as a literal. After the subject ends, trailing stars are
// skipped. Backtracking after a star repeats steps, so the walk length
// is data dependent, quadratic in the worst case. Shortest case (empty
// subject, empty pattern): the walk goes from S_RD to S_TR_RD to S_DONE.
// Output channel (out_valid/out_stall, matched, overflow): one item per
// evaluate. The result sits in an output register; load items keep being
// taken while it waits, and a later evaluate holds its result until the
// register is free. Reset clears counts, overflow flag and both channels;
// memory contents are not cleared and need no clearing pass.
module glob_pattern_matcher #(
    parameter int MAX_PATTERN = gpm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SUBJECT = gpm_pkg::MAX_SUBJECT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       overflow
);

    gpm_pkg::cmd_t    cmd;
    gpm_pkg::status_t st;

    gpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .matched   (matched),
        .overflow  (overflow),
        .cmd       (cmd),
        .st        (st)
    );

    gpm_dp #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_SUBJECT (MAX_SUBJECT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .st        (st)
    );

    a_match_excl_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(matched && overflow))
        else $error("matched reported together with overflow");

    a_eval_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == gpm_pkg::OP_EVAL) |=> in_stall)
        else $error("intake not stalled after evaluate");

    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an evaluate walk");

endmodule
